>>> rtl/ttag_pkg.sv
// Shared types and constants of the transaction table with aging.
`timescale 1ns / 1ps
package ttag_pkg;

    localparam int NUM_BUCKETS  = 256;
    localparam int WAYS         = 4;
    localparam int GT_MAX_BYTES = 32;

    localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int GT_BYTES = 32;
    localparam int GT_BITS = GT_BYTES * 8;
    localparam int LEN_W   = 6;
    localparam int CNT_W   = 11;

    localparam logic [30:0] TIMEOUT_RST  = 31'd30;
    localparam logic [7:0]  INTERVAL_RST = 8'd5;

    localparam logic CFG_TIMEOUT  = 1'b0;
    localparam logic CFG_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        FUNC_STORE  = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_EX,
        S_SW_RD,
        S_SW_EX
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [31:0]       key;
        logic [15:0]       backend;
        logic [31:0]       stamp;
        logic [LEN_W-1:0]  gt_len;
    } t_way;

    typedef t_way [WAYS-1:0] t_meta_row;
    typedef logic [WAYS-1:0][GT_BITS-1:0] t_gt_row;

    localparam int META_W   = $bits(t_meta_row);
    localparam int GT_ROW_W = $bits(t_gt_row);

    typedef struct packed {
        logic             meta_we;
        logic             gt_we;
        logic [BKT_W-1:0] raddr;
        logic [BKT_W-1:0] waddr;
    } t_mem_req;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             free;
        logic [WAY_W-1:0] free_way;
        logic [WAYS-1:0]  aged;
    } t_match;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        backend;
        logic [LEN_W-1:0]   gt_len;
        logic [GT_BITS-1:0] gt;
        logic [CNT_W-1:0]   count;
    } t_result;

endpackage

>>> rtl/transaction_table_with_aging_core.sv
// Top level of the transaction table with aging: sequencer and the two bucket memories.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  request   | i_func, i_tx_id, i_backend, i_gt_*        | start high, busy low
//  result    | o_status, o_found_*, o_evicted_count      | o_done strobe, one cycle
//  config    | i_cfg_index, i_cfg_wdata                  | i_cfg_we high
//
// Store, lookup and delete go from accept to o_done through bucket read,
// way compare with write-back, result register. A tick without a sweep is done in
// the cycle after accept; a sweep walks every bucket row, reading it, then writing it back.
// After reset a clearing pass over all NUM_BUCKETS rows holds busy high.
// Results cannot be held off; the next item may start when busy is low.
`timescale 1ns / 1ps
module transaction_table_with_aging_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_tx_id,
    input  logic [15:0] i_backend,
    input  logic [7:0]  i_gt_len,
    input  logic [63:0] i_gt_word0,
    input  logic [63:0] i_gt_word1,
    input  logic [63:0] i_gt_word2,
    input  logic [63:0] i_gt_word3,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_found_backend,
    output logic [5:0]  o_found_gt_len,
    output logic [63:0] o_found_gt_word0,
    output logic [63:0] o_found_gt_word1,
    output logic [63:0] o_found_gt_word2,
    output logic [63:0] o_found_gt_word3,
    output logic [10:0] o_evicted_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_wdata
);
    import ttag_pkg::*;

    t_mem_req  req;
    t_meta_row meta_rdata, meta_wdata;
    t_gt_row   gt_rdata, gt_wdata;
    t_result   res;

    ttag_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_tx_id      (i_tx_id),
        .i_backend    (i_backend),
        .i_gt_len     (i_gt_len),
        .i_gt         ({i_gt_word3, i_gt_word2, i_gt_word1, i_gt_word0}),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_meta_rdata (meta_rdata),
        .i_gt_rdata   (gt_rdata),
        .o_req        (req),
        .o_meta_wdata (meta_wdata),
        .o_gt_wdata   (gt_wdata),
        .o_done       (o_done),
        .o_result     (res)
    );

    ttag_ram #(.DEPTH(NUM_BUCKETS), .WIDTH(META_W), .AW(BKT_W)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (req.meta_we),
        .i_waddr (req.waddr),
        .i_wdata (meta_wdata),
        .i_raddr (req.raddr),
        .o_rdata (meta_rdata)
    );

    ttag_ram #(.DEPTH(NUM_BUCKETS), .WIDTH(GT_ROW_W), .AW(BKT_W)) u_gt_ram (
        .i_clk   (i_clk),
        .i_we    (req.gt_we),
        .i_waddr (req.waddr),
        .i_wdata (gt_wdata),
        .i_raddr (req.raddr),
        .o_rdata (gt_rdata)
    );

    assign o_status         = res.status;
    assign o_found_backend  = res.backend;
    assign o_found_gt_len   = res.gt_len;
    assign o_found_gt_word0 = res.gt[63:0];
    assign o_found_gt_word1 = res.gt[127:64];
    assign o_found_gt_word2 = res.gt[191:128];
    assign o_found_gt_word3 = res.gt[255:192];
    assign o_evicted_count  = res.count;

endmodule

>>> rtl/ttag_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ttag_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ttag_way_match.sv
// Way compare of one bucket row: key hit, lowest free way and aged entries.
`timescale 1ns / 1ps
module ttag_way_match (
    input  ttag_pkg::t_meta_row i_row,
    input  logic [31:0]         i_key,
    input  logic [31:0]         i_now,
    input  logic [30:0]         i_timeout,
    output ttag_pkg::t_match    o_match
);
    import ttag_pkg::*;

    always_comb begin
        logic [31:0] age;
        o_match = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            age = i_now - i_row[w].stamp;
            if (i_row[w].valid && i_row[w].key == i_key) begin
                o_match.hit     = 1'b1;
                o_match.hit_way = WAY_W'(w);
            end
            if (!i_row[w].valid) begin
                o_match.free     = 1'b1;
                o_match.free_way = WAY_W'(w);
            end
            o_match.aged[w] = i_row[w].valid && (age > {1'b0, i_timeout});
        end
    end

endmodule

>>> rtl/ttag_ctrl.sv
// Sequencer: bucket read-modify-write, aging sweep, clearing pass and configuration.
`timescale 1ns / 1ps
module ttag_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_func,
    input  logic [31:0]            i_tx_id,
    input  logic [15:0]            i_backend,
    input  logic [7:0]             i_gt_len,
    input  logic [ttag_pkg::GT_BITS-1:0] i_gt,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [30:0]            i_cfg_wdata,
    input  ttag_pkg::t_meta_row    i_meta_rdata,
    input  ttag_pkg::t_gt_row      i_gt_rdata,
    output ttag_pkg::t_mem_req     o_req,
    output ttag_pkg::t_meta_row    o_meta_wdata,
    output ttag_pkg::t_gt_row      o_gt_wdata,
    output logic                   o_done,
    output ttag_pkg::t_result      o_result
);
    import ttag_pkg::*;

    t_state             r_state, n_state;
    logic [BKT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [31:0]        r_now, n_now;
    logic [7:0]         r_cd, n_cd;
    logic [30:0]        r_timeout;
    logic [7:0]         r_interval;
    logic               r_done, n_done;
    t_result            r_res, n_res;

    t_func              r_func;
    logic [31:0]        r_tx_id;
    logic [15:0]        r_backend;
    logic [7:0]         r_gt_len;
    logic [GT_BITS-1:0] r_gt;

    t_match             match;
    logic               accept;
    logic [LEN_W-1:0]   len_c;
    logic [GT_BITS-1:0] gt_mask;
    logic [WAY_W-1:0]   way;
    logic [8:0]         cd_next;
    logic [CNT_W:0]     cnt_sum;

    localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(NUM_BUCKETS - 1);

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    ttag_way_match u_match (
        .i_row     (i_meta_rdata),
        .i_key     (r_tx_id),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_match   (match)
    );

    always_comb begin
        len_c = (r_gt_len > 8'(GT_MAX_BYTES)) ? LEN_W'(GT_MAX_BYTES) : r_gt_len[LEN_W-1:0];
        for (int b = 0; b < GT_BYTES; b++) begin
            gt_mask[b*8 +: 8] = (LEN_W'(b) < len_c) ? 8'hFF : 8'h00;
        end
        way     = match.hit ? match.hit_way : match.free_way;
        cd_next = {1'b0, r_cd} + 9'd1;
        cnt_sum = {1'b0, r_count} + (CNT_W + 1)'($countones(match.aged));
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_count      = r_count;
        n_now        = r_now;
        n_cd         = r_cd;
        n_done       = 1'b0;
        n_res        = r_res;
        o_req        = '0;
        o_req.raddr  = BKT_W'(r_tx_id % NUM_BUCKETS);
        o_req.waddr  = BKT_W'(r_tx_id % NUM_BUCKETS);
        o_meta_wdata = i_meta_rdata;
        o_gt_wdata   = i_gt_rdata;
        unique case (r_state)
            S_CLR: begin
                o_req.meta_we = 1'b1;
                o_req.waddr   = r_row;
                o_meta_wdata  = '0;
                n_row         = r_row + 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = S_IDLE;
                    n_row   = '0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (t_func'(i_func) == FUNC_TICK) begin
                        n_now = r_now + 32'd1;
                        if (cd_next >= {1'b0, r_interval}) begin
                            n_cd    = '0;
                            n_row   = '0;
                            n_count = '0;
                            n_state = S_SW_RD;
                        end else begin
                            n_cd   = cd_next[7:0];
                            n_done = 1'b1;
                            n_res  = '0;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                n_done  = 1'b1;
                n_res   = '0;
                n_state = S_IDLE;
                case (r_func)
                    FUNC_STORE: begin
                        if (match.hit || match.free) begin
                            if (!match.hit) begin
                                o_meta_wdata[way].valid  = 1'b1;
                                o_meta_wdata[way].key    = r_tx_id;
                                o_meta_wdata[way].gt_len = '0;
                                o_gt_wdata[way]          = '0;
                            end
                            o_meta_wdata[way].backend = r_backend;
                            o_meta_wdata[way].stamp   = r_now;
                            if (r_gt_len != 8'd0) begin
                                o_meta_wdata[way].gt_len = len_c;
                                o_gt_wdata[way]          = r_gt & gt_mask;
                            end
                            o_req.meta_we = 1'b1;
                            o_req.gt_we   = 1'b1;
                            n_res.status  = ST_OK;
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (match.hit) begin
                            o_meta_wdata[match.hit_way].stamp = r_now;
                            o_req.meta_we = 1'b1;
                            n_res.status  = ST_OK;
                            n_res.backend = i_meta_rdata[match.hit_way].backend;
                            n_res.gt_len  = i_meta_rdata[match.hit_way].gt_len;
                            n_res.gt      = i_gt_rdata[match.hit_way];
                        end else begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                    FUNC_DELETE: begin
                        if (match.hit) begin
                            o_meta_wdata[match.hit_way].valid = 1'b0;
                            o_req.meta_we = 1'b1;
                            n_res.status  = ST_OK;
                        end else begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_res.status = ST_OK;
                    end
                endcase
            end
            S_SW_RD: begin
                o_req.raddr = r_row;
                n_state     = S_SW_EX;
            end
            S_SW_EX: begin
                for (int w = 0; w < WAYS; w++) begin
                    o_meta_wdata[w].valid = i_meta_rdata[w].valid && !match.aged[w];
                end
                o_req.meta_we = 1'b1;
                o_req.waddr   = r_row;
                n_count = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
                if (r_row == LAST_ROW) begin
                    n_done      = 1'b1;
                    n_res       = '0;
                    n_res.count = n_count;
                    n_state     = S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_SW_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_row      <= '0;
            r_count    <= '0;
            r_now      <= '0;
            r_cd       <= '0;
            r_done     <= 1'b0;
            r_timeout  <= TIMEOUT_RST;
            r_interval <= INTERVAL_RST;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_count <= n_count;
            r_now   <= n_now;
            r_cd    <= n_cd;
            r_done  <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                    CFG_INTERVAL: r_interval <= i_cfg_wdata[7:0];
                    default:      r_timeout  <= r_timeout;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_func    <= t_func'(i_func);
            r_tx_id   <= i_tx_id;
            r_backend <= i_backend;
            r_gt_len  <= i_gt_len;
            r_gt      <= i_gt;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
